// File: hdl/rmth_pkg.sv
// Package for the running median unit: widths, defaults, and the command and
// status types passed between the controller and the datapath.
// No dependencies.
`default_nettype none
package rmth_pkg;

  localparam int SAMPLE_W           = 32;
  localparam int MED_W              = 33;
  localparam int HEAP_DEPTH_DEFAULT = 512;
  localparam int DATA_WIDTH_DEFAULT = 32;

  typedef enum logic {
    SEL_LO,
    SEL_UP
  } heap_sel_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SD_INIT,
    OP_SD_READ,
    OP_SD_STEP,
    OP_SU_INIT,
    OP_SU_ROOT,
    OP_SU_READ,
    OP_SU_STEP,
    OP_RESULT
  } op_t;

  typedef struct packed {
    op_t       op;
    heap_sel_t sel;
    logic      use_old;
    logic      drop;
  } cmd_t;

  typedef struct packed {
    logic even;
    logic lower_full;
    logic upper_full;
    logic pass_lo;
    logic pass_up;
    logic i_zero;
    logic sd_done;
    logic su_move;
  } status_t;

endpackage
`default_nettype wire

// File: hdl/rmth_if.sv
// Valid/ready channel interfaces for the running median unit.
// Depends on rmth_pkg.
`default_nettype none
interface rmth_in_if import rmth_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rmth_out_if import rmth_pkg::*; #(parameter int TOT_W = 11) ();
  logic             valid;
  logic             ready;
  logic [MED_W-1:0] median_doubled;
  logic [TOT_W-1:0] total_count;
  logic             dropped;
  modport source (output valid, output median_doubled, output total_count,
                  output dropped, input ready);
  modport sink   (input valid, input median_doubled, input total_count,
                  input dropped, output ready);
endinterface
`default_nettype wire

// File: hdl/rmth_ctrl.sv
// Sequencer for the running median unit: decides the route of each sample and
// steps the datapath through the sift-down and sift-up loops.
// Depends on rmth_pkg.
`default_nettype none
module rmth_ctrl import rmth_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  output logic         out_valid,
  input  wire logic    out_ready,
  input  wire status_t stat,
  output cmd_t         cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SD_RD, S_SD_STEP, S_SU_INIT, S_SU_RD, S_SU_STEP, S_RESULT
  } state_t;

  state_t    state_r, state_nxt;
  heap_sel_t push_r, push_nxt;
  logic      pass_r, pass_nxt;
  logic      drop_r, drop_nxt;
  logic      out_valid_r, out_valid_nxt;
  heap_sel_t pull;

  assign pull      = (push_r == SEL_UP) ? SEL_LO : SEL_UP;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    push_nxt      = push_r;
    pass_nxt      = pass_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '{op: OP_NONE, sel: push_r, use_old: pass_r, drop: drop_r};
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // Even count grows the upper heap, odd count grows the lower heap.
        push_nxt = stat.even ? SEL_UP : SEL_LO;
        drop_nxt = stat.even ? stat.upper_full : stat.lower_full;
        pass_nxt = stat.even ? stat.pass_lo : stat.pass_up;
        cmd.sel  = stat.even ? SEL_LO : SEL_UP;
        if (drop_nxt) begin
          state_nxt = S_RESULT;
        end else if (pass_nxt) begin
          cmd.op    = OP_SD_INIT;
          state_nxt = S_SD_RD;
        end else begin
          state_nxt = S_SU_INIT;
        end
      end
      S_SD_RD: begin
        cmd.op    = OP_SD_READ;
        cmd.sel   = pull;
        state_nxt = S_SD_STEP;
      end
      S_SD_STEP: begin
        cmd.op    = OP_SD_STEP;
        cmd.sel   = pull;
        state_nxt = stat.sd_done ? S_SU_INIT : S_SD_RD;
      end
      S_SU_INIT: begin
        cmd.op    = OP_SU_INIT;
        state_nxt = S_SU_RD;
      end
      S_SU_RD: begin
        if (stat.i_zero) begin
          cmd.op    = OP_SU_ROOT;
          state_nxt = S_RESULT;
        end else begin
          cmd.op    = OP_SU_READ;
          state_nxt = S_SU_STEP;
        end
      end
      S_SU_STEP: begin
        cmd.op    = OP_SU_STEP;
        state_nxt = stat.su_move ? S_SU_RD : S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_RESULT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      push_r      <= SEL_UP;
      pass_r      <= 1'b0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      push_r      <= push_nxt;
      pass_r      <= pass_nxt;
      drop_r      <= drop_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/rmth_dp.sv
// Datapath for the running median unit: both heap memories, their counts and
// cached tops, the sift registers and the result register.
// Depends on rmth_pkg.
`default_nettype none
module rmth_dp import rmth_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int TOT_W      = $clog2(2 * HEAP_DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cmd_t                cmd,
  output status_t                  stat,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic [MED_W-1:0]         med_out,
  output logic [TOT_W-1:0]         tot_out,
  output logic                     drop_out
);

  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CH_W  = CNT_W + 2;

  typedef logic signed [DATA_WIDTH-1:0] val_t;

  val_t mem_lo [HEAP_DEPTH];
  val_t mem_up [HEAP_DEPTH];

  val_t             x_r, old_r, top_lo_r, top_up_r, rd_a_r, rd_b_r;
  logic [CNT_W-1:0] i_r, cnt_lo_r, cnt_up_r;
  logic [MED_W-1:0] med_r;
  logic [TOT_W-1:0] tot_r;
  logic             drop_r;

  logic             is_max, l_ok, r_ok, we;
  logic [CNT_W-1:0] cnt_sel, parent;
  logic [CH_W-1:0]  l_idx, r_idx;
  val_t             cmp_val, best_val, wr_data;
  logic [AW-1:0]    rd_a_addr, rd_b_addr;
  logic [TOT_W-1:0] total;
  logic signed [MED_W-1:0] up_ext, lo_ext;

  function automatic logic ranks_above(input val_t a, input val_t b, input logic mx);
    return mx ? (a > b) : (a < b);
  endfunction

  assign is_max  = (cmd.sel == SEL_LO);
  assign cnt_sel = is_max ? cnt_lo_r : cnt_up_r;
  assign l_idx   = {1'b0, i_r, 1'b1};
  assign r_idx   = l_idx + CH_W'(1);
  assign parent  = (i_r - CNT_W'(1)) >> 1;

  // Pick the child that must rise past the carried value, left before right.
  assign l_ok     = (l_idx < CH_W'(cnt_sel)) && ranks_above(rd_a_r, x_r, is_max);
  assign cmp_val  = l_ok ? rd_a_r : x_r;
  assign r_ok     = (r_idx < CH_W'(cnt_sel)) && ranks_above(rd_b_r, cmp_val, is_max);
  assign best_val = r_ok ? rd_b_r : rd_a_r;

  assign stat.even       = (cnt_lo_r[0] == cnt_up_r[0]);
  assign stat.lower_full = (cnt_lo_r == CNT_W'(HEAP_DEPTH));
  assign stat.upper_full = (cnt_up_r == CNT_W'(HEAP_DEPTH));
  assign stat.pass_lo    = (cnt_lo_r != '0) && (x_r < top_lo_r);
  assign stat.pass_up    = (cnt_up_r != '0) && (x_r > top_up_r);
  assign stat.i_zero     = (i_r == '0);
  assign stat.sd_done    = !l_ok && !r_ok;
  assign stat.su_move    = ranks_above(x_r, rd_a_r, is_max);

  always_comb begin
    we        = 1'b0;
    wr_data   = x_r;
    rd_a_addr = parent[AW-1:0];
    rd_b_addr = r_idx[AW-1:0];
    case (cmd.op)
      OP_SD_READ: rd_a_addr = l_idx[AW-1:0];
      OP_SD_STEP: begin
        we      = 1'b1;
        wr_data = stat.sd_done ? x_r : best_val;
      end
      OP_SU_ROOT: we = 1'b1;
      OP_SU_STEP: begin
        we      = 1'b1;
        wr_data = stat.su_move ? rd_a_r : x_r;
      end
      default: ;
    endcase
  end

  // Memories: one write port and two registered read ports each.
  always_ff @(posedge clk) begin
    if (we && is_max) mem_lo[i_r[AW-1:0]] <= wr_data;
    if (we && !is_max) mem_up[i_r[AW-1:0]] <= wr_data;
    if (cmd.op == OP_SD_READ || cmd.op == OP_SU_READ) begin
      rd_a_r <= is_max ? mem_lo[rd_a_addr] : mem_up[rd_a_addr];
      rd_b_r <= is_max ? mem_lo[rd_b_addr] : mem_up[rd_b_addr];
    end
  end

  assign total  = TOT_W'(cnt_lo_r) + TOT_W'(cnt_up_r);
  assign up_ext = (cnt_up_r != '0) ? MED_W'(top_up_r) : '0;
  assign lo_ext = (cnt_lo_r != '0) ? MED_W'(top_lo_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_lo_r <= '0;
      cnt_up_r <= '0;
    end else if (cmd.op == OP_SU_INIT) begin
      if (is_max) cnt_lo_r <= cnt_lo_r + CNT_W'(1);
      else        cnt_up_r <= cnt_up_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    // The root is mirrored in a register so compares need no memory read.
    if (we && i_r == '0) begin
      if (is_max) top_lo_r <= wr_data;
      else        top_up_r <= wr_data;
    end
    case (cmd.op)
      OP_LOAD:    x_r <= val_t'(in_sample[DATA_WIDTH-1:0]);
      OP_SD_INIT: begin
        i_r   <= '0;
        old_r <= is_max ? top_lo_r : top_up_r;
      end
      OP_SD_STEP: if (!stat.sd_done) i_r <= r_ok ? r_idx[CNT_W-1:0] : l_idx[CNT_W-1:0];
      OP_SU_INIT: begin
        i_r <= cnt_sel;
        if (cmd.use_old) x_r <= old_r;
      end
      OP_SU_STEP: if (stat.su_move) i_r <= parent;
      OP_RESULT: begin
        tot_r  <= total;
        drop_r <= cmd.drop;
        if (total == '0)    med_r <= '0;
        else if (total[0])  med_r <= up_ext + up_ext;
        else                med_r <= up_ext + lo_ext;
      end
      default: ;
    endcase
  end

  assign med_out  = med_r;
  assign tot_out  = tot_r;
  assign drop_out = drop_r;

endmodule
`default_nettype wire

// File: hdl/running_median_two_heaps_unit.sv
// Top level of the running median unit: controller plus datapath.
// Depends on rmth_pkg, rmth_if, rmth_ctrl and rmth_dp.
//
//   Channel   Direction  Payload
//   in_chan   sink       sample (32, signed)
//   out_chan  source     median_doubled (33, signed), total_count, dropped
//
// A sample that goes straight in is loaded, routed and then sifted up the heap that
// grows, one registered memory read plus one compare-and-write per level, until it
// reaches the root or stops below it. A pass-through first sifts down the other heap,
// whose top it replaces; each level and the final check is one registered memory read
// plus one compare-and-write. A dropped sample goes from the route decision to the result.
// Reset is synchronous and clears both counts; the heap memories need no clear.
// The next sample is accepted while a result still waits in the output register.
`default_nettype none
module running_median_two_heaps_unit import rmth_pkg::*; #(
  parameter int HEAP_DEPTH = HEAP_DEPTH_DEFAULT,
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rmth_in_if.sink    in_chan,
  rmth_out_if.source out_chan
);

  localparam int TOT_W = $clog2(2 * HEAP_DEPTH + 1);

  cmd_t    cmd;
  status_t stat;

  rmth_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rmth_dp #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .TOT_W      (TOT_W)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_sample (in_chan.sample),
    .med_out   (out_chan.median_doubled),
    .tot_out   (out_chan.total_count),
    .drop_out  (out_chan.dropped)
  );

endmodule
`default_nettype wire

// File: hdl/rmth_checker.sv
// Port-level checks for the running median unit, bound to the top level.
// Depends on rmth_pkg.
`default_nettype none
module rmth_checker import rmth_pkg::*; #(
  parameter int TOT_W = 11
) (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [MED_W-1:0] median_doubled,
  input wire logic [TOT_W-1:0] total_count,
  input wire logic             dropped
);

  // A stalled result holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(median_doubled)
      && $stable(total_count) && $stable(dropped))
    else $error("result changed while stalled");

  // One sample is worked at a time: no accept right after a transfer in.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a sample is in work");

  // With an odd count the median is one stored sample, so the doubled value is even.
  a_odd_even_lsb: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total_count[0] |-> !median_doubled[0])
    else $error("odd count gave a fractional median");

  // An empty set reports zero.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && total_count == '0 |-> median_doubled == '0)
    else $error("empty set gave a nonzero median");

  // No result comes out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind running_median_two_heaps_unit rmth_checker #(.TOT_W(TOT_W)) u_rmth_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .median_doubled (out_chan.median_doubled),
  .total_count    (out_chan.total_count),
  .dropped        (out_chan.dropped)
);
`default_nettype wire
